// ----- rtl/core/rpbs_pkg.sv -----
package rpbs_pkg;

   localparam int CsrIndexW    = 8;
   localparam int CsrDataW     = 13;
   localparam int MinInkW      = 13;
   localparam int MaxGapW      = 8;
   localparam int GapW         = 9;
   localparam int RowOutW      = 12;
   localparam int HeightW      = 13;

   localparam logic [CsrIndexW-1:0] CSR_MIN_ROW_INK  = CsrIndexW'(0);
   localparam logic [CsrIndexW-1:0] CSR_MAX_GAP_ROWS = CsrIndexW'(1);

   localparam logic [MinInkW-1:0] MIN_ROW_INK_RESET  = MinInkW'(12);
   localparam logic [MaxGapW-1:0] MAX_GAP_ROWS_RESET = MaxGapW'(4);
   localparam logic [GapW-1:0]    GAP_SAT            = GapW'(511);

endpackage

// ----- rtl/core/row_profile_band_segmenter_top.sv -----
// Channel  | Ports                                               | Beat
// ---------+-----------------------------------------------------+-----------------------
// req      | req_valid req_ready req_ink_bit req_row_end         | one pixel, raster order
//          | req_frame_end                                       |
// rsp      | rsp_valid rsp_ready rsp_first_row rsp_last_row      | one closed band
//          | rsp_height_rows                                     |
// csr      | csr_valid csr_ready csr_index csr_wdata             | one register write
//
// One pixel per clock while req_ready: row tally, band state and result update on accept.
// A band result is loaded into the rsp output register at its pixel beat, valid next cycle.
// req_ready is low only while rsp holds a result and rsp_ready is low.
// Synchronous active-high reset clears all but rsp data and loads the register defaults.
// csr_ready is always high.
module row_profile_band_segmenter_top #(
   parameter int MAX_ROWS = 4096,
   parameter int MAX_COLS = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_ink_bit,
   input  logic                                 req_row_end,
   input  logic                                 req_frame_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [rpbs_pkg::RowOutW-1:0]         rsp_first_row,
   output logic [rpbs_pkg::RowOutW-1:0]         rsp_last_row,
   output logic [rpbs_pkg::HeightW-1:0]         rsp_height_rows,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rpbs_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [rpbs_pkg::CsrDataW-1:0]        csr_wdata
);

   localparam int RowW   = $clog2(MAX_ROWS);
   localparam int TallyW = $clog2(MAX_COLS + 1);
   localparam int CmpW   = (TallyW > rpbs_pkg::MinInkW) ? TallyW : rpbs_pkg::MinInkW;
   localparam int ExtW   = (RowW > rpbs_pkg::RowOutW) ? RowW : rpbs_pkg::RowOutW;

   localparam logic [TallyW-1:0] TallyMax = TallyW'(MAX_COLS);
   localparam logic [RowW-1:0]   RowLast  = RowW'(MAX_ROWS - 1);

   logic [rpbs_pkg::MinInkW-1:0] min_row_ink_ff, min_row_ink_in;
   logic [rpbs_pkg::MaxGapW-1:0] max_gap_rows_ff, max_gap_rows_in;

   logic [TallyW-1:0]         pixel_tally_ff, pixel_tally_in;
   logic [RowW-1:0]           row_number_ff, row_number_in;
   logic                      band_open_ff, band_open_in;
   logic [RowW-1:0]           open_start_ff, open_start_in;
   logic [RowW-1:0]           open_stop_ff, open_stop_in;
   logic [rpbs_pkg::GapW-1:0] gap_tally_ff, gap_tally_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rpbs_pkg::RowOutW-1:0]    first_row_ff, first_row_in;
   logic [rpbs_pkg::RowOutW-1:0]    last_row_ff, last_row_in;
   logic [rpbs_pkg::HeightW-1:0]    height_ff, height_in;

   logic                      req_fire;
   logic                      row_done;
   logic [TallyW-1:0]         tally_now;
   logic                      row_hit;
   logic [rpbs_pkg::GapW-1:0] gap_inc;
   logic                      gap_close;
   logic                      open_after_row;
   logic                      frame_close;
   logic                      emit;
   logic [RowW-1:0]           emit_start;
   logic [RowW-1:0]           emit_stop;
   logic [ExtW-1:0]           start_ext;
   logic [ExtW-1:0]           stop_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_row   = first_row_ff;
   assign rsp_last_row    = last_row_ff;
   assign rsp_height_rows = height_ff;

   always_comb begin
      min_row_ink_in  = min_row_ink_ff;
      max_gap_rows_in = max_gap_rows_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rpbs_pkg::CSR_MIN_ROW_INK: begin
               min_row_ink_in = csr_wdata[rpbs_pkg::MinInkW-1:0];
            end
            rpbs_pkg::CSR_MAX_GAP_ROWS: begin
               max_gap_rows_in = csr_wdata[rpbs_pkg::MaxGapW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      row_done  = req_row_end || req_frame_end;
      tally_now = (req_ink_bit && (pixel_tally_ff < TallyMax))
                ? pixel_tally_ff + TallyW'(1) : pixel_tally_ff;
      row_hit   = CmpW'(tally_now) >= CmpW'(min_row_ink_ff);
      gap_inc   = (gap_tally_ff < rpbs_pkg::GAP_SAT)
                ? gap_tally_ff + rpbs_pkg::GapW'(1) : gap_tally_ff;
      gap_close = row_done && !row_hit && band_open_ff
               && (gap_inc > rpbs_pkg::GapW'(max_gap_rows_ff));
      open_after_row = band_open_ff || (row_done && row_hit);
      frame_close    = req_frame_end && !gap_close && open_after_row;
      emit           = gap_close || frame_close;

      if (row_done && row_hit) begin
         emit_start = band_open_ff ? open_start_ff : row_number_ff;
         emit_stop  = row_number_ff;
      end else begin
         emit_start = open_start_ff;
         emit_stop  = open_stop_ff;
      end
      start_ext = ExtW'(emit_start);
      stop_ext  = ExtW'(emit_stop);
   end

   always_comb begin
      pixel_tally_in = pixel_tally_ff;
      row_number_in  = row_number_ff;
      band_open_in   = band_open_ff;
      open_start_in  = open_start_ff;
      open_stop_in   = open_stop_ff;
      gap_tally_in   = gap_tally_ff;
      if (req_fire) begin
         pixel_tally_in = tally_now;
         if (row_done) begin
            pixel_tally_in = '0;
            if (row_number_ff < RowLast) begin
               row_number_in = row_number_ff + RowW'(1);
            end
            if (row_hit) begin
               band_open_in  = 1'b1;
               open_start_in = emit_start;
               open_stop_in  = emit_stop;
               gap_tally_in  = '0;
            end else if (band_open_ff) begin
               gap_tally_in = gap_inc;
               if (gap_close) begin
                  band_open_in = 1'b0;
                  gap_tally_in = '0;
               end
            end
         end
         if (req_frame_end) begin
            pixel_tally_in = '0;
            row_number_in  = '0;
            band_open_in   = 1'b0;
            open_start_in  = '0;
            open_stop_in   = '0;
            gap_tally_in   = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      first_row_in = first_row_ff;
      last_row_in  = last_row_ff;
      height_in    = height_ff;
      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
         first_row_in = start_ext[rpbs_pkg::RowOutW-1:0];
         last_row_in  = stop_ext[rpbs_pkg::RowOutW-1:0];
         height_in    = {1'b0, stop_ext[rpbs_pkg::RowOutW-1:0]}
                      - {1'b0, start_ext[rpbs_pkg::RowOutW-1:0]}
                      + rpbs_pkg::HeightW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_row_ink_ff  <= rpbs_pkg::MIN_ROW_INK_RESET;
         max_gap_rows_ff <= rpbs_pkg::MAX_GAP_ROWS_RESET;
         pixel_tally_ff  <= '0;
         row_number_ff   <= '0;
         band_open_ff    <= 1'b0;
         open_start_ff   <= '0;
         open_stop_ff    <= '0;
         gap_tally_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         min_row_ink_ff  <= min_row_ink_in;
         max_gap_rows_ff <= max_gap_rows_in;
         pixel_tally_ff  <= pixel_tally_in;
         row_number_ff   <= row_number_in;
         band_open_ff    <= band_open_in;
         open_start_ff   <= open_start_in;
         open_stop_ff    <= open_stop_in;
         gap_tally_ff    <= gap_tally_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_row_ff <= first_row_in;
      last_row_ff  <= last_row_in;
      height_ff    <= height_in;
   end

`ifndef ASSERT_OFF
   a_gap_clear_when_closed: assert property (@(posedge clock) disable iff (reset)
      !band_open_ff |-> gap_tally_ff == '0)
      else $error("gap tally nonzero with no open band");

   a_band_order: assert property (@(posedge clock) disable iff (reset)
      band_open_ff |-> (open_start_ff <= open_stop_ff) && (open_stop_ff <= row_number_ff))
      else $error("open band rows out of order");

   a_tally_bound: assert property (@(posedge clock) disable iff (reset)
      pixel_tally_ff <= TallyMax)
      else $error("pixel tally beyond column limit");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_frame_end |=> row_number_ff == '0 && !band_open_ff
                                    && pixel_tally_ff == '0)
      else $error("frame end did not clear band state");

   a_emit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire && emit |=> rsp_valid_ff)
      else $error("band result lost");
`endif

endmodule
